@@ rtl/dbr_pkg.sv @@
// dbr_pkg: shared types, constants, register indexes and the power-of-ten
// tables for the decimal rescale pipeline. no dependencies.
package dbr_pkg;

	localparam int unsigned DigMax = 19;

	typedef struct packed {
		logic [63:0] raw_bytes;
		logic [3:0]  byte_count;
		logic [4:0]  source_precision;
		logic [4:0]  source_scale;
	} in_t;

	typedef struct packed {
		logic signed [63:0] decimal_value;
		logic               status_code;
	} out_t;

	typedef struct packed {
		logic        pass;
		logic        neg;
		logic        fail;
		logic        up;
		logic [4:0]  dexp;
		logic [63:0] v;
	} side_t;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	localparam logic IDX_TP = 1'b0;
	localparam logic IDX_TS = 1'b1;

	localparam logic [64:0] Two64 = 65'd1 << 64;

	function automatic logic [63:0] pow10(input logic [4:0] e);
		logic [63:0] p;
		unique case (e)
			5'd0:  p = 64'd1;
			5'd1:  p = 64'd10;
			5'd2:  p = 64'd100;
			5'd3:  p = 64'd1000;
			5'd4:  p = 64'd10000;
			5'd5:  p = 64'd100000;
			5'd6:  p = 64'd1000000;
			5'd7:  p = 64'd10000000;
			5'd8:  p = 64'd100000000;
			5'd9:  p = 64'd1000000000;
			5'd10: p = 64'd10000000000;
			5'd11: p = 64'd100000000000;
			5'd12: p = 64'd1000000000000;
			5'd13: p = 64'd10000000000000;
			5'd14: p = 64'd100000000000000;
			5'd15: p = 64'd1000000000000000;
			5'd16: p = 64'd10000000000000000;
			5'd17: p = 64'd100000000000000000;
			5'd18: p = 64'd1000000000000000000;
			5'd19: p = 64'd10000000000000000000;
			default: p = 64'd1;
		endcase
		return p;
	endfunction

	// floor(2^64 / 10^e), exponent zero not used
	function automatic logic [63:0] recip10(input logic [4:0] e);
		logic [63:0] r;
		unique case (e)
			5'd1:  r = 64'(Two64 / 65'd10);
			5'd2:  r = 64'(Two64 / 65'd100);
			5'd3:  r = 64'(Two64 / 65'd1000);
			5'd4:  r = 64'(Two64 / 65'd10000);
			5'd5:  r = 64'(Two64 / 65'd100000);
			5'd6:  r = 64'(Two64 / 65'd1000000);
			5'd7:  r = 64'(Two64 / 65'd10000000);
			5'd8:  r = 64'(Two64 / 65'd100000000);
			5'd9:  r = 64'(Two64 / 65'd1000000000);
			5'd10: r = 64'(Two64 / 65'd10000000000);
			5'd11: r = 64'(Two64 / 65'd100000000000);
			5'd12: r = 64'(Two64 / 65'd1000000000000);
			5'd13: r = 64'(Two64 / 65'd10000000000000);
			5'd14: r = 64'(Two64 / 65'd100000000000000);
			5'd15: r = 64'(Two64 / 65'd1000000000000000);
			5'd16: r = 64'(Two64 / 65'd10000000000000000);
			5'd17: r = 64'(Two64 / 65'd100000000000000000);
			5'd18: r = 64'(Two64 / 65'd1000000000000000000);
			5'd19: r = 64'(Two64 / 65'd10000000000000000000);
			default: r = 64'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] clamp19(input logic [4:0] x);
		return (x > 5'(DigMax)) ? 5'(DigMax) : x;
	endfunction

endpackage

@@ rtl/decimal_bytes_rescale.sv @@
// decimal_bytes_rescale: top level, configuration registers, range check
// and result register. depends on dbr_pkg, dbr_front, dbr_div, dbr_mul.
// pipeline from the accepting edge to the result register: 3 front stages,
// 8 divider stages, 3 multiplier stages, 1 output stage.
// throughput one transaction per cycle. busy is never raised and the
// receiver cannot stall. reset clears valid bits and sets target 18/0.
module decimal_bytes_rescale #(
	parameter int RESULT_BITS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dbr_pkg::in_t  item,
	input  logic          wr_en,
	input  logic          wr_index,
	input  logic [4:0]    wr_data,
	output logic          done,
	output dbr_pkg::out_t result
);
	localparam logic [63:0] Half = 64'd1 << (RESULT_BITS - 1);
	localparam logic [63:0] Mask = Half + (Half - 64'd1);

	function automatic logic [63:0] wrap(input logic [63:0] x);
		logic [63:0] y;
		y = x & Mask;
		if ((y & Half) != 64'd0) begin
			y = y | ~Mask;
		end
		return y;
	endfunction

	logic [4:0] tp_q, ts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q <= 5'd18;
			ts_q <= 5'd0;
		end else if (wr_en) begin
			unique case (wr_index)
				dbr_pkg::IDX_TP: tp_q <= wr_data;
				dbr_pkg::IDX_TS: ts_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic           f_vld, d_vld, m_vld, d_rnz;
	logic [63:0]    f_mag, f_dvs, d_quo, m_prod;
	dbr_pkg::side_t f_side, d_side, d_side2, m_side;

	dbr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .item(item),
		.tp_cfg(tp_q), .ts_cfg(ts_q), .out_valid(f_vld), .mag(f_mag),
		.divisor(f_dvs), .side(f_side)
	);

	dbr_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(f_vld), .dividend(f_mag),
		.divisor(f_dvs), .in_side(f_side), .out_valid(d_vld), .quotient(d_quo),
		.rem_nz(d_rnz), .out_side(d_side)
	);

	always_comb begin
		d_side2      = d_side;
		d_side2.fail = d_side.fail | d_rnz;
	end

	dbr_mul u_mul (
		.clk(clk), .arst_n(arst_n), .in_valid(d_vld), .a(d_quo), .in_side(d_side2),
		.out_valid(m_vld), .product(m_prod), .out_side(m_side)
	);

	logic f_all;
	assign f_all = m_side.fail || (m_side.neg ? (m_prod > Half) : (m_prod > Half - 64'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= m_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (m_side.pass) begin
			result.decimal_value <= wrap(m_side.v);
			result.status_code   <= dbr_pkg::STATUS_OK;
		end else if (f_all) begin
			result.decimal_value <= 64'sd0;
			result.status_code   <= dbr_pkg::STATUS_FAIL;
		end else begin
			result.decimal_value <= wrap(m_side.neg ? (64'd0 - m_prod) : m_prod);
			result.status_code   <= dbr_pkg::STATUS_OK;
		end
	end
endmodule

@@ rtl/dbr_front.sv @@
// dbr_front: three-stage front end: sign extension, magnitude, integer
// digit check and divisor selection. depends on dbr_pkg.
module dbr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  dbr_pkg::in_t   item,
	input  logic [4:0]     tp_cfg,
	input  logic [4:0]     ts_cfg,
	output logic           out_valid,
	output logic [63:0]    mag,
	output logic [63:0]    divisor,
	output dbr_pkg::side_t side
);
	logic        vld_s1, vld_s2, vld_s3;
	logic [63:0] v_s1;
	logic        pass_s1;
	logic [4:0]  tp_s1, ts_s1, ss_s1;

	logic [63:0] v_ext;
	logic [3:0]  n;

	always_comb begin
		n = (item.byte_count > 4'd8) ? 4'd8 : item.byte_count;
		v_ext = 64'd0;
		for (int i = 1; i <= 8; i++) begin
			if (n == 4'(i)) begin
				for (int b = 0; b < 64; b++) begin
					v_ext[b] = (b < 8 * i) ? item.raw_bytes[b] : item.raw_bytes[8 * i - 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		v_s1    <= v_ext;
		pass_s1 <= (item.source_precision == tp_cfg) && (item.source_scale == ts_cfg);
		tp_s1   <= dbr_pkg::clamp19(tp_cfg);
		ts_s1   <= dbr_pkg::clamp19(ts_cfg);
		ss_s1   <= dbr_pkg::clamp19(item.source_scale);
	end

	// stage 2: magnitude and check exponent
	logic [63:0] mag_s2, v_s2;
	logic        pass_s2, neg_s2, chk_en_s2, up_s2;
	logic [4:0]  chk_exp_s2, dexp_s2;
	logic [5:0]  e_sum;

	assign e_sum = 6'(tp_s1) - 6'(ts_s1) + 6'(ss_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		v_s2    <= v_s1;
		pass_s2 <= pass_s1;
		neg_s2  <= v_s1[63];
		mag_s2  <= v_s1[63] ? (~v_s1 + 64'd1) : v_s1;
		if (tp_s1 <= ts_s1) begin
			chk_en_s2  <= 1'b1;
			chk_exp_s2 <= ss_s1;
		end else begin
			chk_en_s2  <= (e_sum <= 6'(dbr_pkg::DigMax));
			chk_exp_s2 <= e_sum[4:0];
		end
		up_s2   <= (ts_s1 >= ss_s1);
		dexp_s2 <= (ts_s1 >= ss_s1) ? (ts_s1 - ss_s1) : (ss_s1 - ts_s1);
	end

	// stage 3: integer digit check and divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag       <= mag_s2;
		divisor   <= up_s2 ? 64'd1 : dbr_pkg::pow10(dexp_s2);
		side.pass <= pass_s2;
		side.neg  <= neg_s2;
		side.fail <= chk_en_s2 && (mag_s2 >= dbr_pkg::pow10(chk_exp_s2));
		side.up   <= up_s2;
		side.dexp <= dexp_s2;
		side.v    <= v_s2;
	end

	assign out_valid = vld_s3;
endmodule

@@ rtl/dbr_div.sv @@
// dbr_div: eight-stage divider by a power of ten: reciprocal estimate from a
// constant table, remainder and one correction step. depends on dbr_pkg.
module dbr_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [63:0]    dividend,
	input  logic [63:0]    divisor,
	input  dbr_pkg::side_t in_side,
	output logic           out_valid,
	output logic [63:0]    quotient,
	output logic           rem_nz,
	output dbr_pkg::side_t out_side
);
	logic [63:0] recip;
	assign recip = dbr_pkg::recip10(in_side.dexp);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	logic [63:0]    a_s1, a_s2, a_s3, a_s4, a_s5, a_s6, a_s7;
	logic [63:0]    d_s1, d_s2, d_s3, d_s4, d_s5, d_s6, d_s7;
	dbr_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic [63:0]    r_s1, pll_s1, phl_s1;
	logic [31:0]    rh_s2;
	logic [63:0]    plh_s2, phh_s3;
	logic [65:0]    mid_s2, mid_s3;
	logic [63:0]    qe_s4, qe_s5, qe_s6, qe_s7;
	logic [63:0]    pl_s5, pr_s6, rem_s7;
	logic [31:0]    ph1_s5, ph2_s6;
	logic [63:0]    quo_s8;
	logic           rnz_s8;
	logic           adj;

	assign adj = (rem_s7 >= d_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		// high half of dividend times reciprocal
		a_s1    <= dividend;
		d_s1    <= divisor;
		r_s1    <= recip;
		pll_s1  <= dividend[31:0] * recip[31:0];
		phl_s1  <= dividend[63:32] * recip[31:0];
		side_s1 <= in_side;

		a_s2    <= a_s1;
		d_s2    <= d_s1;
		rh_s2   <= r_s1[63:32];
		plh_s2  <= a_s1[31:0] * r_s1[63:32];
		mid_s2  <= 66'(phl_s1) + 66'(pll_s1[63:32]);
		side_s2 <= side_s1;

		a_s3    <= a_s2;
		d_s3    <= d_s2;
		phh_s3  <= a_s2[63:32] * rh_s2;
		mid_s3  <= mid_s2 + 66'(plh_s2);
		side_s3 <= side_s2;

		a_s4    <= a_s3;
		d_s4    <= d_s3;
		qe_s4   <= phh_s3 + 64'(mid_s3[65:32]);
		side_s4 <= side_s3;

		// estimate times divisor, low half
		a_s5    <= a_s4;
		d_s5    <= d_s4;
		qe_s5   <= qe_s4;
		pl_s5   <= qe_s4[31:0] * d_s4[31:0];
		ph1_s5  <= qe_s4[63:32] * d_s4[31:0];
		side_s5 <= side_s4;

		a_s6    <= a_s5;
		d_s6    <= d_s5;
		qe_s6   <= qe_s5;
		ph2_s6  <= qe_s5[31:0] * d_s5[63:32];
		pr_s6   <= pl_s5 + {ph1_s5, 32'd0};
		side_s6 <= side_s5;

		a_s7    <= a_s6;
		d_s7    <= d_s6;
		qe_s7   <= qe_s6;
		rem_s7  <= a_s6 - pr_s6 - {ph2_s6, 32'd0};
		side_s7 <= side_s6;

		// estimate is low by at most one
		if (side_s7.up) begin
			quo_s8 <= a_s7;
			rnz_s8 <= 1'b0;
		end else begin
			quo_s8 <= qe_s7 + 64'(adj);
			rnz_s8 <= adj ? (rem_s7 != d_s7) : (rem_s7 != 64'd0);
		end
		side_s8 <= side_s7;
	end

	assign out_valid = vld_s8;
	assign quotient  = quo_s8;
	assign rem_nz    = rnz_s8;
	assign out_side  = side_s8;
endmodule

@@ rtl/dbr_mul.sv @@
// dbr_mul: three-stage 64x64 low-half multiplier by a power of ten,
// one 32x32 partial product per stage. depends on dbr_pkg.
module dbr_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [63:0]    a,
	input  dbr_pkg::side_t in_side,
	output logic           out_valid,
	output logic [63:0]    product,
	output dbr_pkg::side_t out_side
);
	logic [63:0] b;
	assign b = in_side.up ? dbr_pkg::pow10(in_side.dexp) : 64'd1;

	logic           vld_s1, vld_s2, vld_s3;
	logic [63:0]    a_s1, b_s1, a_s2, b_s2;
	logic [63:0]    acc_s1, acc_s2, acc_s3;
	dbr_pkg::side_t side_s1, side_s2, side_s3;
	logic [31:0]    pp1, pp2;

	assign pp1 = a_s1[63:32] * b_s1[31:0];
	assign pp2 = a_s2[31:0] * b_s2[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= a;
		b_s1    <= b;
		acc_s1  <= a[31:0] * b[31:0];
		side_s1 <= in_side;
		a_s2    <= a_s1;
		b_s2    <= b_s1;
		acc_s2  <= acc_s1 + {pp1, 32'd0};
		side_s2 <= side_s1;
		acc_s3  <= acc_s2 + {pp2, 32'd0};
		side_s3 <= side_s2;
	end

	assign out_valid = vld_s3;
	assign product   = acc_s3;
	assign out_side  = side_s3;
endmodule
